/* rtl/sps_pkg.sv */
`timescale 1ns / 1ps

package sps_pkg;

  // defaults for the top-level parameters
  localparam int unsigned SegmentLenDef = 64;
  localparam int unsigned ValueBitsDef  = 32;

  // fixed stream payload layout
  localparam int unsigned InDataBits  = 64;
  localparam int unsigned OutMaskBits = 64;
  localparam int unsigned OutCntBits  = 7;
  localparam int unsigned OutDataBits = 72;

  // divisor width: holds the first odd divisor whose square passes the range end
  function automatic int unsigned div_bits(input int unsigned value_bits);
    return value_bits / 2 + 1;
  endfunction

endpackage

/* rtl/segment_prime_sieve.sv */
`timescale 1ns / 1ps

// segment prime sieve
// input stream: one request per item, tdata carries range_start (bits 31:0)
// and range_end (bits 63:32), both cut to the low VALUE_BITS bits
// output stream: one result per request, tdata carries the prime mask
// (bit k set when range_start + k is prime) and the prime count; tuser is
// the range_bad flag (start below two, empty range or longer than SEGMENT_LEN)
// a rejected request returns a zero mask and zero count
// odd divisors d = 3, 5, 7 ... with d*d <= range_end are walked one at a time;
// for each the first multiple in the segment comes from a shared bit-serial
// remainder unit, or is 2d when start < 2d; then multiples are struck one a cycle
// s_axis_tready is high only while no request is in work; a finished result
// sits in the output register, so a new request may enter while it waits
// a stalled receiver holds the result; the next one waits in its final state
// reset clears the sequencer, the remainder unit control and the output valid; nothing else needs clearing
module segment_prime_sieve
  import sps_pkg::*;
#(
  parameter int unsigned SEGMENT_LEN = SegmentLenDef,
  parameter int unsigned VALUE_BITS  = ValueBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,   // range_start[31:0], range_end[63:32]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata,   // prime_mask[63:0], prime_count[70:64], pad
  output logic                   m_axis_tuser    // range_bad
);

  localparam int unsigned DBits = div_bits(VALUE_BITS);
  localparam int unsigned IdxW  = (SEGMENT_LEN > 1) ? $clog2(SEGMENT_LEN) : 1;
  localparam int unsigned OffW  = ((DBits > IdxW) ? DBits : IdxW) + 1;
  localparam int unsigned CntW  = $clog2(SEGMENT_LEN + 1);
  localparam int unsigned VW1   = VALUE_BITS + 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StStrike = 3'd3;
  localparam logic [2:0] StCount  = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [VALUE_BITS-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [IdxW-1:0]        diff_q, diff_d;
  logic [DBits-1:0]       d_q, d_d;
  logic [VW1-1:0]         sq_q, sq_d;
  logic [OffW-1:0]        off_q, off_d;
  logic [SEGMENT_LEN-1:0] mask_q, mask_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   bad_q, bad_d;

  logic                   out_valid_q, out_valid_d;
  logic [OutMaskBits-1:0] out_mask_q, out_mask_d;
  logic [OutCntBits-1:0]  out_cnt_q, out_cnt_d;
  logic                   out_bad_q, out_bad_d;

  logic [VALUE_BITS-1:0]  in_lo, in_hi;
  logic [VW1-1:0]         in_diff;
  logic                   in_bad;
  logic [SEGMENT_LEN-1:0] init_mask;
  logic [VW1-1:0]         two_d;
  logic                   rem_start, rem_done;
  logic [DBits-1:0]       rem;
  logic                   out_free;

  assign in_lo   = s_axis_tdata[VALUE_BITS-1:0];
  assign in_hi   = s_axis_tdata[32 +: VALUE_BITS];
  assign in_diff = {1'b0, in_hi} - {1'b0, in_lo};
  assign in_bad  = (in_lo < VALUE_BITS'(2)) || (in_hi < in_lo)
                 || (in_diff >= VW1'(SEGMENT_LEN));

  // all candidates in range, even ones struck except the value two
  always_comb begin
    for (int k = 0; k < SEGMENT_LEN; k++) begin
      init_mask[k] = (VW1'(k) <= in_diff)
                   && ((in_lo[0] ^ k[0]) || ((in_lo == VALUE_BITS'(2)) && (k == 0)));
    end
  end

  assign two_d    = VW1'({d_q, 1'b0});
  assign out_free = !out_valid_q || m_axis_tready;

  sps_rem_unit #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DBits)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (lo_q),
    .divisor_i  (d_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    diff_d    = diff_q;
    d_d       = d_q;
    sq_d      = sq_q;
    off_d     = off_q;
    mask_d    = mask_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    bad_d     = bad_q;
    rem_start = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          lo_d   = in_lo;
          hi_d   = in_hi;
          diff_d = IdxW'(in_diff);
          d_d    = DBits'(3);
          sq_d   = VW1'(9);
          if (in_bad) begin
            mask_d  = '0;
            cnt_d   = '0;
            bad_d   = 1'b1;
            state_d = StFinish;
          end else begin
            mask_d  = init_mask;
            bad_d   = 1'b0;
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (sq_q > {1'b0, hi_q}) begin
          idx_d   = '0;
          cnt_d   = '0;
          state_d = StCount;
        end else if ({1'b0, lo_q} < two_d) begin
          // first multiple to strike is twice the divisor
          off_d   = OffW'(two_d - {1'b0, lo_q});
          state_d = StStrike;
        end else begin
          rem_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (rem_done) begin
          off_d   = (rem == '0) ? '0 : OffW'({1'b0, d_q} - {1'b0, rem});
          state_d = StStrike;
        end
      end
      StStrike: begin
        if (off_q <= OffW'(diff_q)) begin
          mask_d[off_q[IdxW-1:0]] = 1'b0;
          off_d = off_q + OffW'(d_q);
        end else begin
          // (d+2)^2 = d^2 + 4d + 4
          sq_d    = sq_q + VW1'({d_q, 2'b00}) + VW1'(4);
          d_d     = d_q + DBits'(2);
          state_d = StCheck;
        end
      end
      StCount: begin
        cnt_d = cnt_q + CntW'(mask_q[idx_q]);
        if (idx_q == diff_q) begin
          state_d = StFinish;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;
    out_cnt_d   = out_cnt_q;
    out_bad_d   = out_bad_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == StFinish) && out_free) begin
      out_valid_d = 1'b1;
      out_mask_d  = OutMaskBits'(mask_q);
      out_cnt_d   = OutCntBits'(cnt_q);
      out_bad_d   = bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    diff_q     <= diff_d;
    d_q        <= d_d;
    sq_q       <= sq_d;
    off_q      <= off_d;
    mask_q     <= mask_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    bad_q      <= bad_d;
    out_mask_q <= out_mask_d;
    out_cnt_q  <= out_cnt_d;
    out_bad_q  <= out_bad_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_cnt_q, out_mask_q};
  assign m_axis_tuser  = out_bad_q;

`ifndef SYNTHESIS
  // a rejected request carries an empty mask and a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("rejected request with non-empty result");

  // the count never exceeds the segment length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_cnt_q <= OutCntBits'(SEGMENT_LEN)))
    else $error("prime count beyond segment length");

  // only odd divisors from three upwards strike
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStrike) |-> (d_q[0] && (d_q >= DBits'(3))))
    else $error("bad divisor while striking");

  // the remainder unit reports only to a waiting sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == StDiv))
    else $error("remainder done outside divide state");

  // a result loaded into a busy, stalled output register would be lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
`endif

endmodule

/* rtl/sps_rem_unit.sv */
`timescale 1ns / 1ps

module sps_rem_unit
  import sps_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned DIV_BITS   = div_bits(ValueBitsDef)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [DIV_BITS-1:0]   divisor_i,
  output logic                  done_o,
  output logic [DIV_BITS-1:0]   rem_o
);

  localparam int unsigned CntW = $clog2(VALUE_BITS);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] dvd_q, dvd_d;
  logic [DIV_BITS-1:0]   dsr_q, dsr_d;
  logic [DIV_BITS-1:0]   rem_q, rem_d;
  logic [DIV_BITS:0]     trial;

  // restoring remainder, one dividend bit a cycle
  assign trial = {rem_q, dvd_q[VALUE_BITS-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_BITS - 1);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DIV_BITS'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[DIV_BITS-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
